FILE: rtl/u8u2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

    // Replacement character '?'
    localparam logic [15:0] C_REPL_UNIT = 16'h003F;

    // Bytes skipped after a four-, five- or six-byte lead
    localparam logic [2:0] C_SKIP_LEAD4 = 3'd3;
    localparam logic [2:0] C_SKIP_LEAD5 = 3'd4;
    localparam logic [2:0] C_SKIP_LEAD6 = 3'd5;

    // Total lengths of the sequences that are assembled
    localparam logic [1:0] C_SEQ_NONE = 2'd0;
    localparam logic [1:0] C_SEQ_TWO  = 2'd2;
    localparam logic [1:0] C_SEQ_THREE = 2'd3;

    // Results caused by one byte. All but the last one are always '?',
    // so only the count and the final unit are carried.
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] last_unit;
    } t_group;

endpackage

FILE: rtl/u8u2_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2 stream interfaces
// Valid/ready channels for the byte input and the code unit output.
// ----------------------------------------------------------------------------
interface u8u2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface u8u2_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;

    modport source (output valid, output code_unit, output run_last, input ready);
    modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

FILE: rtl/u8u2_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_dec
// Decode state and per-byte decode logic. State advances on i_commit.
// ----------------------------------------------------------------------------
module u8u2_dec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  logic             i_commit,
    output u8u2_pkg::t_group o_group
);
    import u8u2_pkg::*;

    logic [1:0]  r_seq_len;
    logic [1:0]  r_gathered;
    logic [15:0] r_partial;
    logic [2:0]  r_skip;

    logic [1:0]  n_seq_len;
    logic [1:0]  n_gathered;
    logic [15:0] n_partial;
    logic [2:0]  n_skip;

    // fresh-byte decode
    logic        f_count;
    logic [15:0] f_unit;
    logic [1:0]  f_seq_len;
    logic [15:0] f_partial;
    logic [2:0]  f_skip;

    logic        w_cont;
    logic [15:0] w_acc;
    logic [1:0]  w_gath_inc;

    assign w_cont     = (i_byte inside {[8'h80:8'hBF]});
    assign w_acc      = {r_partial[9:0], i_byte[5:0]};
    assign w_gath_inc = r_gathered + 2'd1;

    always_comb begin
        f_count   = 1'b1;
        f_unit    = C_REPL_UNIT;
        f_seq_len = C_SEQ_NONE;
        f_partial = '0;
        f_skip    = '0;
        if (i_byte inside {[8'h00:8'h7F]}) begin
            f_count = (i_byte != 8'h00);
            f_unit  = {8'h00, i_byte};
        end else if (i_byte inside {[8'hC0:8'hDF]}) begin
            if (!i_end) begin
                f_count   = 1'b0;
                f_seq_len = C_SEQ_TWO;
                f_partial = {11'd0, i_byte[4:0]};
            end
        end else if (i_byte inside {[8'hE0:8'hEF]}) begin
            if (!i_end) begin
                f_count   = 1'b0;
                f_seq_len = C_SEQ_THREE;
                f_partial = {12'd0, i_byte[3:0]};
            end
        end else if (i_byte inside {[8'hF0:8'hF7]}) begin
            f_skip = i_end ? 3'd0 : C_SKIP_LEAD4;
        end else if (i_byte inside {[8'hF8:8'hFB]}) begin
            f_skip = i_end ? 3'd0 : C_SKIP_LEAD5;
        end else if (i_byte inside {[8'hFC:8'hFD]}) begin
            f_skip = i_end ? 3'd0 : C_SKIP_LEAD6;
        end
    end

    always_comb begin
        n_seq_len         = r_seq_len;
        n_gathered        = r_gathered;
        n_partial         = r_partial;
        n_skip            = r_skip;
        o_group.count     = 2'd0;
        o_group.last_unit = C_REPL_UNIT;

        if (r_skip != 3'd0) begin
            n_skip = r_skip - 3'd1;
        end else if (r_seq_len != C_SEQ_NONE && w_cont) begin
            if (w_gath_inc >= r_seq_len) begin
                o_group.count     = {1'b0, (w_acc != 16'h0000)};
                o_group.last_unit = w_acc;
                n_seq_len         = C_SEQ_NONE;
                n_gathered        = '0;
                n_partial         = '0;
            end else if (i_end) begin
                o_group.count = w_gath_inc;
            end else begin
                n_gathered = w_gath_inc;
                n_partial  = w_acc;
            end
        end else begin
            // no or broken sequence: one '?' per gathered byte, then fresh decode
            o_group.count     = ((r_seq_len != C_SEQ_NONE) ? r_gathered : 2'd0)
                                + {1'b0, f_count};
            o_group.last_unit = f_count ? f_unit : C_REPL_UNIT;
            n_seq_len         = f_seq_len;
            n_gathered        = (f_seq_len != C_SEQ_NONE) ? 2'd1 : 2'd0;
            n_partial         = f_partial;
            n_skip            = f_skip;
        end

        if (i_end) begin
            n_seq_len  = C_SEQ_NONE;
            n_gathered = '0;
            n_partial  = '0;
            n_skip     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len  <= C_SEQ_NONE;
            r_gathered <= '0;
            r_partial  <= '0;
            r_skip     <= '0;
        end else if (i_commit) begin
            r_seq_len  <= n_seq_len;
            r_gathered <= n_gathered;
            r_partial  <= n_partial;
            r_skip     <= n_skip;
        end
    end

endmodule

FILE: rtl/u8u2_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_obuf
// Result register: holds one byte's result group and drains it one code
// unit per transfer.
// ----------------------------------------------------------------------------
module u8u2_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  u8u2_pkg::t_group i_group,
    output logic             o_free,
    u8u2_unit_if.source      o_out
);
    import u8u2_pkg::*;

    logic [1:0]  r_cnt;
    logic [15:0] r_last_unit;
    logic        w_xfer;

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.run_last  = (r_cnt == 2'd1);
    assign o_out.code_unit = (r_cnt == 2'd1) ? r_last_unit : C_REPL_UNIT;
    assign w_xfer          = o_out.valid && o_out.ready;
    // free now, or the last unit leaves this cycle
    assign o_free          = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (w_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_last_unit <= i_group.last_unit;
        end
    end

endmodule

FILE: rtl/utf8_to_ucs2_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_core
// UTF-8 byte stream to UCS-2 code unit decoder, one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per input transfer and gives 16-bit UCS-2 code units.
// ASCII passes through, two- and three-byte sequences are assembled, and
// anything malformed or beyond the BMP comes out as '?' (leads of four to six
// bytes also swallow the 3, 4 or 5 bytes after them). A decoded zero gives
// no output. Flag stream_end on the last byte to flush a partial sequence.
// Throughput: one byte per cycle while the output is ready and each byte
// yields at most one code unit; a byte that yields n units (up to 3) holds
// the result register until all have left, since that register drains one
// unit per transfer. A byte passes the input register, then the result
// register, before its first output. run_last marks the final unit caused by a byte.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u2_byte_if.sink   i_in,
    u8u2_unit_if.source o_out
);
    import u8u2_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;

    t_group     w_group;
    logic       w_buf_free;
    logic       w_commit;

    // A registered byte is decoded and committed once the result register
    // can take its group; bytes with no result commit the same way.
    assign w_commit   = r_in_valid && w_buf_free;
    assign i_in.ready = !r_in_valid || w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_end  <= i_in.stream_end;
        end
    end

    // decode state and per-byte logic
    u8u2_dec u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (r_byte),
        .i_end    (r_end),
        .i_commit (w_commit),
        .o_group  (w_group)
    );

    // result register, drains one code unit per transfer
    u8u2_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_commit && (w_group.count != 2'd0)),
        .i_group (w_group),
        .o_free  (w_buf_free),
        .o_out   (o_out)
    );

endmodule
